>>> rtl/core/gfm_pkg.sv
// Shared types, opcodes, pattern constants and helpers of the glob filename matcher.
package gfm_pkg;

  localparam int MAX_PATTERN_DEF = 32;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_BYTE   = 2'd2,
    OP_END    = 2'd3
  } gfm_op_t;

  typedef struct packed {
    gfm_op_t    opcode;
    logic [7:0] byte_value;
  } gfm_in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } gfm_out_t;

  typedef struct packed {
    logic fwd;
    logic carry;
    logic seed;
  } gfm_link_t;

  typedef struct packed {
    logic wr;
    logic consume;
    logic drop;
    logic started;
  } gfm_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/gfm_cell.sv
// One pattern position of the matcher chain: stored byte, start bit and active bit.
module gfm_cell #(
  parameter int LEN_W = 6,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gfm_pkg::gfm_ctl_t  ctl,
  input  logic [7:0]         byte_value,
  input  logic [LEN_W-1:0]   len,
  input  gfm_pkg::gfm_link_t link_in,
  output gfm_pkg::gfm_link_t link_out,
  output logic               acc
);

  logic [7:0] pat_r;
  logic       seed_r;
  logic       act_r;
  logic       act_nxt;

  logic valid;
  logic at_end;
  logic is_star;
  logic is_semi;
  logic lit_match;
  logic act_eff;
  logic closed;

  assign valid     = LEN_W'(INDEX) < len;
  assign at_end    = LEN_W'(INDEX) == len;
  assign is_star   = pat_r == gfm_pkg::CH_STAR;
  assign is_semi   = pat_r == gfm_pkg::CH_SEMI;
  assign lit_match = (pat_r == gfm_pkg::CH_QMARK) ||
                     (gfm_pkg::fold(pat_r) == gfm_pkg::fold(byte_value));
  assign act_eff   = ctl.started ? act_r : link_in.seed;
  assign closed    = (valid & act_eff & is_star) | link_in.fwd | link_in.carry;

  assign link_out.fwd   = valid & act_eff & ~is_star & ~is_semi & lit_match;
  assign link_out.carry = valid & is_star & closed;
  assign link_out.seed  = valid & seed_r;

  assign acc = act_r & ((valid & is_semi) | at_end);

  always_comb begin
    act_nxt = act_r;
    if (ctl.drop) begin
      act_nxt = 1'b0;
    end else if (ctl.consume) begin
      act_nxt = closed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && at_end) begin
      pat_r  <= byte_value;
      seed_r <= (byte_value == gfm_pkg::CH_SEMI) |
                (link_in.seed & (byte_value == gfm_pkg::CH_STAR));
    end
  end

endmodule

>>> rtl/core/glob_filename_matcher_core.sv
// Top level of the glob filename matcher: control, chain of position cells, result register.
// A name-end transaction shows its result in the cycle after its acceptance.
// Throughput: one transaction per cycle; each name byte updates every position
// in a single pass along the cell chain, where star runs propagate like a carry.
// A waiting result stalls the input; a new transaction enters in the cycle the result leaves.
// Reset (rst_n low, synchronous) empties the pattern and clears all match and flag state but the output data register.
module glob_filename_matcher_core #(
  parameter int MAX_PATTERN = gfm_pkg::MAX_PATTERN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gfm_pkg::gfm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gfm_pkg::gfm_out_t out_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic              started_r, started_nxt;
  logic              act_end_r, act_end_nxt;
  logic              out_valid_r, out_valid_nxt;
  gfm_pkg::gfm_out_t out_data_r, out_data_nxt;

  logic              in_acc;
  logic              room;
  logic              any_acc;
  gfm_pkg::gfm_ctl_t ctl;
  gfm_pkg::gfm_link_t links [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] acc_vec;

  assign in_ready  = ~out_valid_r | out_ready;
  assign in_acc    = in_valid & in_ready;
  assign room      = len_r < LEN_W'(MAX_PATTERN);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    ctl.wr      = 1'b0;
    ctl.consume = 1'b0;
    ctl.drop    = 1'b0;
    ctl.started = started_r;
    if (in_acc) begin
      unique case (in_data.opcode)
        gfm_pkg::OP_APPEND: begin
          ctl.wr   = room;
          ctl.drop = 1'b1;
        end
        gfm_pkg::OP_CLEAR: ctl.drop    = 1'b1;
        gfm_pkg::OP_BYTE:  ctl.consume = 1'b1;
        gfm_pkg::OP_END:   ctl.drop    = 1'b1;
        default:           ctl.drop    = 1'b0;
      endcase
    end
  end

  assign links[0] = '{fwd: 1'b0, carry: 1'b0, seed: 1'b1};

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    gfm_cell #(
      .LEN_W(LEN_W),
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .byte_value(in_data.byte_value),
      .len       (len_r),
      .link_in   (links[i]),
      .link_out  (links[i+1]),
      .acc       (acc_vec[i])
    );
  end

  assign acc_vec[MAX_PATTERN] = act_end_r & (len_r == LEN_W'(MAX_PATTERN));
  assign any_acc = |acc_vec;

  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    started_nxt   = started_r;
    act_end_nxt   = act_end_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      unique case (in_data.opcode)
        gfm_pkg::OP_APPEND: begin
          started_nxt = 1'b0;
          act_end_nxt = 1'b0;
          if (room) begin
            len_nxt = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        gfm_pkg::OP_CLEAR: begin
          started_nxt = 1'b0;
          act_end_nxt = 1'b0;
          len_nxt     = '0;
          ovf_nxt     = 1'b0;
        end
        gfm_pkg::OP_BYTE: begin
          started_nxt = 1'b1;
          act_end_nxt = links[MAX_PATTERN].fwd | links[MAX_PATTERN].carry;
        end
        gfm_pkg::OP_END: begin
          started_nxt                   = 1'b0;
          act_end_nxt                   = 1'b0;
          out_valid_nxt                 = 1'b1;
          out_data_nxt.matched          = started_r & any_acc;
          out_data_nxt.pattern_overflow = ovf_r;
        end
        default: begin
          started_nxt = started_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      started_r   <= 1'b0;
      act_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      started_r   <= started_nxt;
      act_end_r   <= act_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
